/* design/swz_pkg.sv */
package swz_pkg;

    localparam int WINDOW_ROWS = 32;
    localparam int CHANNELS    = 64;
    localparam int SAMPLE_BITS = 24;

    localparam int ROW_W  = 5;
    localparam int CH_W   = 6;
    localparam int ADDR_W = ROW_W + CH_W;
    localparam int FILL_W = 6;
    localparam int SUM_W  = 29;
    localparam int SQ_W   = 52;
    localparam int XSQ_W  = 48;
    localparam int S2_W   = 58;
    localparam int D_W    = 57;
    localparam int ND_W   = D_W + 5;
    localparam int A_W    = 30;
    localparam int AM2_W  = 2 * A_W;
    localparam int R_W    = AM2_W + 5 + 24;
    localparam int DV_W   = ND_W + 32;
    localparam int Z_W    = 16;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(31);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(15);
    localparam logic [FILL_W-1:0] EMIT_FILL = FILL_W'(WINDOW_ROWS - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WINDOW_ROWS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_OLD,
        ST_UPD,
        ST_S2,
        ST_DIFF,
        ST_WRD,
        ST_AVAL,
        ST_ASQ,
        ST_RHS,
        ST_DINIT,
        ST_DIV,
        ST_SQI,
        ST_SQ,
        ST_OUT,
        ST_FIN
    } swz_state_t;

    typedef struct packed {
        logic ready;
        logic rd_item;
        logic take_old;
        logic update;
        logic calc_s2;
        logic calc_d;
        logic rd_win;
        logic calc_a;
        logic calc_sq;
        logic calc_r;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic out_load;
        logic finish;
    } swz_cmd_t;

    typedef struct packed {
        logic emit;
        logic flat;
        logic out_free;
        logic k_last;
    } swz_sts_t;

endpackage

/* design/swz_ctrl.sv */
module swz_ctrl
    import swz_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  swz_sts_t sts,
    output swz_cmd_t cmd
);

    swz_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_RD;
            ST_RD:    state_next = ST_OLD;
            ST_OLD:   state_next = ST_UPD;
            ST_UPD:   state_next = sts.emit ? ST_S2 : ST_FIN;
            ST_S2:    state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_WRD;
            ST_WRD:   state_next = ST_AVAL;
            ST_AVAL:  state_next = sts.flat ? ST_OUT : ST_ASQ;
            ST_ASQ:   state_next = ST_RHS;
            ST_RHS:   state_next = ST_DINIT;
            ST_DINIT:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST) state_next = ST_SQI;
            end
            ST_SQI:
            begin
                state_next = ST_SQ;
                cnt_next   = '0;
            end
            ST_SQ:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == SQRT_LAST) state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free) state_next = sts.k_last ? ST_FIN : ST_WRD;
            end
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:  cmd.ready     = 1'b1;
            ST_RD:    cmd.rd_item   = 1'b1;
            ST_OLD:   cmd.take_old  = 1'b1;
            ST_UPD:   cmd.update    = 1'b1;
            ST_S2:    cmd.calc_s2   = 1'b1;
            ST_DIFF:  cmd.calc_d    = 1'b1;
            ST_WRD:   cmd.rd_win    = 1'b1;
            ST_AVAL:  cmd.calc_a    = 1'b1;
            ST_ASQ:   cmd.calc_sq   = 1'b1;
            ST_RHS:   cmd.calc_r    = 1'b1;
            ST_DINIT: cmd.div_init  = 1'b1;
            ST_DIV:   cmd.div_step  = 1'b1;
            ST_SQI:   cmd.sqrt_init = 1'b1;
            ST_SQ:    cmd.sqrt_step = 1'b1;
            ST_OUT:   cmd.out_load  = sts.out_free;
            ST_FIN:   cmd.finish    = 1'b1;
            default:  cmd           = '0;
        endcase
    end

endmodule

/* design/swz_dp.sv */
module swz_dp
    import swz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  swz_cmd_t    cmd,
    output swz_sts_t    sts,
    input  logic        in_valid,
    input  logic [31:0] in_data,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_data,
    output logic        out_user,
    output logic        out_last
);

    logic [SAMPLE_BITS-1:0] win_mem [WINDOW_ROWS*CHANNELS];
    logic [SUM_W-1:0]       sum_mem [CHANNELS];
    logic [SQ_W-1:0]        sq_mem  [CHANNELS];

    logic                    accept;
    logic [CH_W-1:0]         ch_reg;
    logic [SAMPLE_BITS-1:0]  x_reg;
    logic                    eor_reg;
    logic [ROW_W-1:0]        write_row_reg;
    logic [FILL_W-1:0]       rows_filled_reg;
    logic [CHANNELS-1:0]     row_seen_reg;
    logic [CHANNELS-1:0]     stat_vld_reg;
    logic [ROW_W-1:0]        k_reg;

    logic [ADDR_W-1:0]       win_addr;
    logic                    win_we;
    logic [SAMPLE_BITS-1:0]  win_rd_reg;
    logic [SUM_W-1:0]        sum_rd_reg;
    logic [SQ_W-1:0]         sq_rd_reg;
    logic                    stat_vld_rd_reg;

    logic [SAMPLE_BITS-1:0]  old_reg;
    logic [SUM_W-1:0]        sum_base_reg;
    logic [SQ_W-1:0]         sq_base_reg;
    logic [XSQ_W-1:0]        xsq_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [S2_W-1:0]         s2_reg;
    logic [D_W-1:0]          d_reg;
    logic [A_W-1:0]          a_reg;
    logic [AM2_W-1:0]        am2_reg;
    logic [R_W-1:0]          r_reg;
    logic [DV_W-1:0]         rem_reg;
    logic [DV_W-1:0]         div_reg;
    logic [31:0]             q_reg;
    logic                    sat_reg;
    logic [31:0]             qc_reg;
    logic [15:0]             root_reg;
    logic [15:0]             bit_reg;

    logic                    out_valid_reg;
    logic [31:0]             out_data_reg;
    logic                    out_user_reg;
    logic                    out_last_reg;

    logic [23:0]             x_mag, old_mag;
    logic [XSQ_W-1:0]        oldsq;
    logic [SUM_W-1:0]        sum_new;
    logic [SQ_W-1:0]         sq_new;
    logic [SUM_W-1:0]        s_mag;
    logic [S2_W-1:0]         nq;
    logic [A_W-1:0]          a_mag;
    logic [A_W-1:0]          v_ext, s_ext, a_new;
    logic [AM2_W+4:0]        am2_31;
    logic [DV_W-1:0]         nd_full;
    logic                    div_ge;
    logic [15:0]             cand;
    logic [31:0]             cand_sq;
    logic [16:0]             r_sum;
    logic [15:0]             r_val;
    logic [Z_W-1:0]          z_val;
    logic                    out_free;

    assign accept   = cmd.ready && in_valid;
    assign out_free = !out_valid_reg || out_ready;

    assign sts.emit     = rows_filled_reg >= EMIT_FILL;
    assign sts.flat     = (d_reg == '0);
    assign sts.out_free = out_free;
    assign sts.k_last   = (k_reg == ROW_W'(WINDOW_ROWS - 1));

    always_comb
    begin
        if (cmd.rd_win)
            win_addr = {write_row_reg + ROW_W'(1) + k_reg, ch_reg};
        else
            win_addr = {write_row_reg, ch_reg};
    end
    assign win_we = cmd.update;

    always_ff @(posedge clk)
    begin
        if (win_we) win_mem[win_addr] <= x_reg;
        win_rd_reg <= win_mem[win_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            sum_mem[ch_reg] <= sum_new;
            sq_mem[ch_reg]  <= sq_new;
        end
        sum_rd_reg <= sum_mem[ch_reg];
        sq_rd_reg  <= sq_mem[ch_reg];
    end

    assign x_mag   = x_reg[23] ? 24'(-x_reg) : x_reg;
    assign old_mag = old_reg[23] ? 24'(-old_reg) : old_reg;
    assign oldsq   = old_mag * old_mag;
    assign sum_new = sum_base_reg + SUM_W'($signed(x_reg)) - SUM_W'($signed(old_reg));
    assign sq_new  = sq_base_reg + SQ_W'(xsq_reg) - SQ_W'(oldsq);

    assign s_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : sum_reg;
    assign nq      = S2_W'({sq_reg, 5'b0});

    assign v_ext   = {{(A_W-SAMPLE_BITS){win_rd_reg[SAMPLE_BITS-1]}}, win_rd_reg};
    assign s_ext   = {sum_reg[SUM_W-1], sum_reg};
    assign a_new   = (v_ext << 5) - s_ext;
    assign a_mag   = a_reg[A_W-1] ? A_W'(-a_reg) : a_reg;
    assign am2_31  = {am2_reg, 5'b0} - (AM2_W+5)'(am2_reg);
    assign nd_full = {d_reg, 5'b0, 32'b0};

    assign div_ge  = rem_reg >= div_reg;

    assign cand    = root_reg | bit_reg;
    assign cand_sq = cand * cand;

    assign r_sum   = {1'b0, root_reg} + 17'd1;
    assign r_val   = r_sum[16:1];

    always_comb
    begin
        if (sts.flat)
            z_val = '0;
        else if (a_reg[A_W-1])
            z_val = Z_W'(17'd0 - {1'b0, r_val});
        else if (r_val[15])
            z_val = 16'h7FFF;
        else
            z_val = r_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_row_reg   <= '0;
            rows_filled_reg <= '0;
            row_seen_reg    <= '0;
            stat_vld_reg    <= '0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                row_seen_reg[ch_reg] <= 1'b1;
                stat_vld_reg[ch_reg] <= 1'b1;
            end
            if (cmd.finish && eor_reg)
            begin
                write_row_reg <= write_row_reg + ROW_W'(1);
                row_seen_reg  <= '0;
                if (rows_filled_reg < FULL_FILL)
                    rows_filled_reg <= rows_filled_reg + FILL_W'(1);
            end
            if (cmd.calc_s2)
                k_reg <= '0;
            else if (cmd.out_load)
                k_reg <= k_reg + ROW_W'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= in_data[CH_W-1:0];
            x_reg   <= in_data[CH_W +: SAMPLE_BITS];
            eor_reg <= in_last;
        end
        if (cmd.rd_item)
            stat_vld_rd_reg <= stat_vld_reg[ch_reg];
        if (cmd.take_old)
        begin
            if (rows_filled_reg == FULL_FILL || row_seen_reg[ch_reg])
                old_reg <= win_rd_reg;
            else
                old_reg <= '0;
            sum_base_reg <= stat_vld_rd_reg ? sum_rd_reg : '0;
            sq_base_reg  <= stat_vld_rd_reg ? sq_rd_reg : '0;
            xsq_reg      <= x_mag * x_mag;
        end
        if (cmd.update)
        begin
            sum_reg <= sum_new;
            sq_reg  <= sq_new;
        end
        if (cmd.calc_s2)
            s2_reg <= s_mag * s_mag;
        if (cmd.calc_d)
            d_reg <= (nq > s2_reg) ? D_W'(nq - s2_reg) : '0;
        if (cmd.calc_a)
            a_reg <= a_new;
        if (cmd.calc_sq)
            am2_reg <= a_mag * a_mag;
        if (cmd.calc_r)
            r_reg <= {am2_31, 24'b0};
        if (cmd.div_init)
        begin
            rem_reg <= DV_W'(r_reg);
            div_reg <= nd_full >> 1;
            sat_reg <= DV_W'(r_reg) >= nd_full;
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_ge) rem_reg <= rem_reg - div_reg;
            div_reg <= div_reg >> 1;
            q_reg   <= {q_reg[30:0], div_ge};
        end
        if (cmd.sqrt_init)
        begin
            qc_reg   <= sat_reg ? 32'hFFFF_FFFF : q_reg;
            root_reg <= '0;
            bit_reg  <= 16'h8000;
        end
        else if (cmd.sqrt_step)
        begin
            if (cand_sq <= qc_reg) root_reg <= cand;
            bit_reg <= bit_reg >> 1;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {5'b0, ch_reg, k_reg, z_val};
            out_user_reg <= sts.flat;
            out_last_reg <= sts.k_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule

/* design/sliding_window_zscore_normalizer_top.sv */
// Sliding-window z-score normaliser. Each request carries one Q.12 sample for one
// channel; tlast marks the final sample of a row and moves the window on by one row.
// The last 32 rows of all 64 channels are kept in an on-chip sample memory, together
// with a running sum and sum of squares per channel. Once 31 rows are complete, each
// sample causes its channel's whole window column to be sent out, oldest row first,
// as (x - mean) / s in Q.11, with s the sample deviation (divisor N-1), rounded to
// nearest and saturated; tlast marks the newest row. A flat window gives zeros with
// tuser set. The block works on one request at a time and takes no new one until the
// last is finished. Each request reads the old window sample and updates the channel's
// sums; one that emits then, per result, reads a window sample and, unless the window
// is flat, runs the one-bit-per-cycle divider (32 steps) and square-root unit (16
// steps) that form the z-score. A stalled output holds the block until it is taken.
module sliding_window_zscore_normalizer_top
    import swz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // channel [5:0], sample [29:6], zero [31:30]
    input  logic        s_axis_tlast,  // end_of_row
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // normalized_value [15:0], row_position [20:16],
                                       // out_channel [26:21], zero [31:27]
    output logic        m_axis_tuser,  // flat_window
    output logic        m_axis_tlast   // last
);

    swz_cmd_t cmd;
    swz_sts_t sts;

    // The controller sequences each request; the datapath holds all storage.
    swz_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    swz_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign s_axis_tready = cmd.ready;

endmodule
